// File: src/rc2_pkg.sv
// Shared codes, constants and the pi permutation table for the RC2 block.
// No dependencies; imported by rc2_block_cipher and rc2_checker.
`default_nettype none

package rc2_pkg;

	// request codes
	localparam logic [1:0] REQ_KEY = 2'd0;
	localparam logic [1:0] REQ_ENC = 2'd1;
	localparam logic [1:0] REQ_DEC = 2'd2;

	// status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_KEY_LEN = 2'd1;
	localparam logic [1:0] STS_ROUNDS  = 2'd2;

	localparam int unsigned KEY_BYTES   = 128;
	localparam int unsigned EK_WORDS    = 64;
	localparam int unsigned NUM_OPS     = 72;
	localparam logic [4:0]  ROUNDS_STD  = 5'd16;
	localparam logic [4:0]  ROUNDS_ZERO = 5'd0;
	localparam logic [4:0]  ROUNDS_RST  = 5'd16;

	localparam logic [7:0] PI_TAB [256] = '{
		8'd217, 8'd120, 8'd249, 8'd196, 8'd25,  8'd221, 8'd181, 8'd237,
		8'd40,  8'd233, 8'd253, 8'd121, 8'd74,  8'd160, 8'd216, 8'd157,
		8'd198, 8'd126, 8'd55,  8'd131, 8'd43,  8'd118, 8'd83,  8'd142,
		8'd98,  8'd76,  8'd100, 8'd136, 8'd68,  8'd139, 8'd251, 8'd162,
		8'd23,  8'd154, 8'd89,  8'd245, 8'd135, 8'd179, 8'd79,  8'd19,
		8'd97,  8'd69,  8'd109, 8'd141, 8'd9,   8'd129, 8'd125, 8'd50,
		8'd189, 8'd143, 8'd64,  8'd235, 8'd134, 8'd183, 8'd123, 8'd11,
		8'd240, 8'd149, 8'd33,  8'd34,  8'd92,  8'd107, 8'd78,  8'd130,
		8'd84,  8'd214, 8'd101, 8'd147, 8'd206, 8'd96,  8'd178, 8'd28,
		8'd115, 8'd86,  8'd192, 8'd20,  8'd167, 8'd140, 8'd241, 8'd220,
		8'd18,  8'd117, 8'd202, 8'd31,  8'd59,  8'd190, 8'd228, 8'd209,
		8'd66,  8'd61,  8'd212, 8'd48,  8'd163, 8'd60,  8'd182, 8'd38,
		8'd111, 8'd191, 8'd14,  8'd218, 8'd70,  8'd105, 8'd7,   8'd87,
		8'd39,  8'd242, 8'd29,  8'd155, 8'd188, 8'd148, 8'd67,  8'd3,
		8'd248, 8'd17,  8'd199, 8'd246, 8'd144, 8'd239, 8'd62,  8'd231,
		8'd6,   8'd195, 8'd213, 8'd47,  8'd200, 8'd102, 8'd30,  8'd215,
		8'd8,   8'd232, 8'd234, 8'd222, 8'd128, 8'd82,  8'd238, 8'd247,
		8'd132, 8'd170, 8'd114, 8'd172, 8'd53,  8'd77,  8'd106, 8'd42,
		8'd150, 8'd26,  8'd210, 8'd113, 8'd90,  8'd21,  8'd73,  8'd116,
		8'd75,  8'd159, 8'd208, 8'd94,  8'd4,   8'd24,  8'd164, 8'd236,
		8'd194, 8'd224, 8'd65,  8'd110, 8'd15,  8'd81,  8'd203, 8'd204,
		8'd36,  8'd145, 8'd175, 8'd80,  8'd161, 8'd244, 8'd112, 8'd57,
		8'd153, 8'd124, 8'd58,  8'd133, 8'd35,  8'd184, 8'd180, 8'd122,
		8'd252, 8'd2,   8'd54,  8'd91,  8'd37,  8'd85,  8'd151, 8'd49,
		8'd45,  8'd93,  8'd250, 8'd152, 8'd227, 8'd138, 8'd146, 8'd174,
		8'd5,   8'd223, 8'd41,  8'd16,  8'd103, 8'd108, 8'd186, 8'd201,
		8'd211, 8'd0,   8'd230, 8'd207, 8'd225, 8'd158, 8'd168, 8'd44,
		8'd99,  8'd22,  8'd1,   8'd63,  8'd88,  8'd226, 8'd137, 8'd169,
		8'd13,  8'd56,  8'd52,  8'd27,  8'd171, 8'd51,  8'd255, 8'd176,
		8'd187, 8'd72,  8'd12,  8'd95,  8'd185, 8'd177, 8'd205, 8'd46,
		8'd197, 8'd243, 8'd219, 8'd71,  8'd229, 8'd165, 8'd156, 8'd119,
		8'd10,  8'd166, 8'd32,  8'd104, 8'd254, 8'd127, 8'd193, 8'd173
	};

	function automatic logic [7:0] pi_lookup(input logic [7:0] x);
		return PI_TAB[x];
	endfunction

endpackage

`default_nettype wire

// File: src/rc2_block_cipher.sv
// RC2 block cipher top level: key buffer, key expansion sequencer and round engine.
// Depends on rc2_pkg (codes, pi table).
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  request   | req_valid/req_stall | req_type, key_byte, key_last, block_in
//  response  | rsp_valid/rsp_stall | block_out, status
//  config    | cfg_we              | cfg_wdata (round count setting)
//
// Encrypt/decrypt does one expanded-key memory read per round update, plus an
// extra address step for each of the eight mash updates, whose key index
// depends on the data. A last key byte runs the expansion over the 128-byte
// key memory, each byte being read and then written.
// Reset clears control state and marks the expanded key as all zeros.
// A result waits in the output register while the next item is taken; the
// engine stalls only when a new result finds that register still full.
`default_nettype none

module rc2_block_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  key_byte,
	input  wire logic        key_last,
	input  wire logic [63:0] block_in,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [63:0]      block_out,
	output logic [1:0]       status
);
	import rc2_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FWD, ST_MID, ST_BWD, ST_COPY, ST_CRYPT, ST_DONE
	} state_t;

	typedef struct packed {
		logic       mash;
		logic [1:0] j;
		logic [5:0] kaddr;
	} op_info_t;

	localparam logic [6:0] LAST_OP   = 7'(NUM_OPS - 1);
	localparam logic [6:0] LAST_BYTE = 7'(KEY_BYTES - 1);
	localparam logic [7:0] LEN_MAX   = 8'(KEY_BYTES);
	localparam logic [7:0] CNT_SAT   = 8'd255;

	// Position in the encrypt sequence; decrypt runs it backwards.
	function automatic op_info_t op_decode(input logic [6:0] op, input logic dec);
		logic [6:0] e;
		op_info_t   o;
		e = dec ? (LAST_OP - op) : op;
		o.mash = ((e >= 7'd20) && (e < 7'd24)) || ((e >= 7'd48) && (e < 7'd52));
		o.j = e[1:0];
		if (e < 7'd20)
			o.kaddr = e[5:0];
		else if (e < 7'd48)
			o.kaddr = 6'(e - 7'd4);
		else
			o.kaddr = 6'(e - 7'd8);
		return o;
	endfunction

	function automatic logic [15:0] rotl_j(input logic [15:0] v, input logic [1:0] j);
		logic [15:0] r;
		unique case (j)
			2'd0: r = {v[14:0], v[15]};
			2'd1: r = {v[13:0], v[15:14]};
			2'd2: r = {v[12:0], v[15:13]};
			2'd3: r = {v[10:0], v[15:11]};
		endcase
		return r;
	endfunction

	function automatic logic [15:0] rotr_j(input logic [15:0] v, input logic [1:0] j);
		logic [15:0] r;
		unique case (j)
			2'd0: r = {v[0], v[15:1]};
			2'd1: r = {v[1:0], v[15:2]};
			2'd2: r = {v[2:0], v[15:3]};
			2'd3: r = {v[4:0], v[15:5]};
		endcase
		return r;
	endfunction

	state_t           state_q;
	logic [4:0]       rounds_q;
	logic [7:0]       key_count_q;
	logic [7:0]       len_q;
	logic [6:0]       idx_q;
	logic [7:0]       prev_q;
	logic [7:0]       lo_q;
	logic             sub_q;
	logic             dec_q;
	logic [6:0]       op_q;
	logic [3:0][15:0] r_q;
	logic [1:0]       res_status_q;
	logic             ek_loaded_q;
	logic             out_valid_q;
	logic [63:0]      out_block_q;
	logic [1:0]       out_status_q;

	// memories and their ports
	logic [7:0]  kb_mem [KEY_BYTES];
	logic [15:0] ek_mem [EK_WORDS];
	logic        kb_we;
	logic [6:0]  kb_waddr, kb_raddr;
	logic [7:0]  kb_wdata, kb_rd_s1;
	logic        ek_we;
	logic [5:0]  ek_waddr, ek_raddr;
	logic [15:0] ek_wdata, ek_rd_s1;

	logic        req_acc;
	logic [7:0]  cnt_inc;
	logic [6:0]  mid_idx;
	logic [7:0]  pi_idx, pi_val;
	op_info_t    cur_op, nxt_op;
	logic [15:0] a, b, c, d, f, kw, new_word;

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign block_out = out_block_q;
	assign status    = out_status_q;

	assign cnt_inc = (key_count_q < CNT_SAT) ? (key_count_q + 8'd1) : key_count_q;
	assign mid_idx = 7'(LEN_MAX - len_q);
	assign pi_val  = pi_lookup(pi_idx);

	// key memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (kb_we)
			kb_mem[kb_waddr] <= kb_wdata;
		kb_rd_s1 <= kb_mem[kb_raddr];
	end

	// expanded key memory
	always_ff @(posedge clk) begin
		if (ek_we)
			ek_mem[ek_waddr] <= ek_wdata;
		ek_rd_s1 <= ek_mem[ek_raddr];
	end

	// key memory addressing for buffering and the expansion passes
	always_comb begin
		kb_we    = 1'b0;
		kb_waddr = key_count_q[6:0];
		kb_wdata = key_byte;
		kb_raddr = idx_q;
		pi_idx   = kb_rd_s1;
		unique case (state_q)
			ST_IDLE: begin
				kb_we = req_acc && (req_type == REQ_KEY) && (key_count_q < LEN_MAX);
			end
			ST_FWD: begin
				kb_raddr = idx_q - len_q[6:0];
				pi_idx   = prev_q + kb_rd_s1;
				kb_we    = sub_q;
				kb_waddr = idx_q;
				kb_wdata = pi_val;
			end
			ST_MID: begin
				kb_raddr = mid_idx;
				kb_we    = sub_q;
				kb_waddr = mid_idx;
				kb_wdata = pi_val;
			end
			ST_BWD: begin
				kb_raddr = idx_q + len_q[6:0];
				pi_idx   = prev_q ^ kb_rd_s1;
				kb_we    = sub_q;
				kb_waddr = idx_q;
				kb_wdata = pi_val;
			end
			default: ;
		endcase
	end

	// copy pass packs byte pairs into expanded-key words
	assign ek_we    = (state_q == ST_COPY) && sub_q && idx_q[0];
	assign ek_waddr = idx_q[6:1];
	assign ek_wdata = {kb_rd_s1, lo_q};

	// round engine: key address for this op, or prefetch for the next one
	assign cur_op = op_decode(op_q, dec_q);
	assign nxt_op = op_decode(op_q + 7'd1, dec_q);

	always_comb begin
		if (sub_q)
			ek_raddr = nxt_op.kaddr;
		else if (cur_op.mash)
			ek_raddr = r_q[cur_op.j - 2'd1][5:0];
		else
			ek_raddr = cur_op.kaddr;
	end

	// each op updates one of the four register words
	assign a  = r_q[cur_op.j];
	assign b  = r_q[cur_op.j + 2'd1];
	assign c  = r_q[cur_op.j + 2'd2];
	assign d  = r_q[cur_op.j + 2'd3];
	assign f  = (b & ~d) + (c & d);
	assign kw = ek_loaded_q ? ek_rd_s1 : 16'd0;

	always_comb begin
		priority if (cur_op.mash)
			new_word = dec_q ? (a - kw) : (a + kw);
		else if (dec_q)
			new_word = rotr_j(a, cur_op.j) - (f + kw);
		else
			new_word = rotl_j(a + f + kw, cur_op.j);
	end

	// sequencer, control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rounds_q     <= ROUNDS_RST;
			key_count_q  <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			prev_q       <= '0;
			lo_q         <= '0;
			sub_q        <= 1'b0;
			dec_q        <= 1'b0;
			op_q         <= '0;
			r_q          <= '0;
			res_status_q <= STS_OK;
			ek_loaded_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_block_q  <= '0;
			out_status_q <= STS_OK;
		end else begin
			if (cfg_we)
				rounds_q <= cfg_wdata;
			// drain the output register; the done state reloads it itself
			if (out_valid_q && !rsp_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						unique case (req_type)
							REQ_KEY: begin
								key_count_q <= key_last ? 8'd0 : cnt_inc;
								if (key_last) begin
									r_q         <= '0;
									sub_q       <= 1'b0;
									len_q       <= cnt_inc;
									prev_q      <= key_byte;
									idx_q       <= cnt_inc[6:0];
									priority if (cnt_inc > LEN_MAX) begin
										res_status_q <= STS_KEY_LEN;
										state_q      <= ST_DONE;
									end else if (rounds_q != ROUNDS_ZERO &&
											rounds_q != ROUNDS_STD) begin
										res_status_q <= STS_ROUNDS;
										state_q      <= ST_DONE;
									end else if (cnt_inc == LEN_MAX) begin
										state_q <= ST_MID;
									end else begin
										state_q <= ST_FWD;
									end
								end
							end
							REQ_ENC, REQ_DEC: begin
								r_q     <= block_in;
								dec_q   <= (req_type == REQ_DEC);
								op_q    <= '0;
								sub_q   <= 1'b0;
								state_q <= ST_CRYPT;
							end
							default: ;
						endcase
					end
				end
				// forward fill of the tail of the key table
				ST_FWD: begin
					sub_q <= !sub_q;
					if (sub_q) begin
						prev_q <= pi_val;
						if (idx_q == LAST_BYTE)
							state_q <= ST_MID;
						else
							idx_q <= idx_q + 7'd1;
					end
				end
				// single substitution at the effective-key boundary
				ST_MID: begin
					sub_q <= !sub_q;
					if (sub_q) begin
						prev_q  <= pi_val;
						idx_q   <= (mid_idx == 7'd0) ? 7'd0 : (mid_idx - 7'd1);
						state_q <= (mid_idx == 7'd0) ? ST_COPY : ST_BWD;
					end
				end
				// backward pass down to byte zero
				ST_BWD: begin
					sub_q <= !sub_q;
					if (sub_q) begin
						prev_q <= pi_val;
						if (idx_q == 7'd0)
							state_q <= ST_COPY;
						else
							idx_q <= idx_q - 7'd1;
					end
				end
				ST_COPY: begin
					sub_q <= !sub_q;
					if (sub_q) begin
						if (!idx_q[0])
							lo_q <= kb_rd_s1;
						if (idx_q == LAST_BYTE) begin
							ek_loaded_q  <= 1'b1;
							res_status_q <= STS_OK;
							state_q      <= ST_DONE;
						end else begin
							idx_q <= idx_q + 7'd1;
						end
					end
				end
				ST_CRYPT: begin
					if (!sub_q) begin
						sub_q <= 1'b1;
					end else begin
						r_q[cur_op.j] <= new_word;
						if (op_q == LAST_OP) begin
							res_status_q <= STS_OK;
							state_q      <= ST_DONE;
						end else begin
							op_q  <= op_q + 7'd1;
							sub_q <= !nxt_op.mash;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !rsp_stall) begin
						out_valid_q  <= 1'b1;
						out_block_q  <= r_q;
						out_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/rc2_checker.sv
// Port-level checker for rc2_block_cipher, attached by the bind below.
// Depends on rc2_pkg (request and status codes).
`default_nettype none

module rc2_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_stall,
	input wire logic [1:0]  req_type,
	input wire logic        key_last,
	input wire logic        rsp_valid,
	input wire logic        rsp_stall,
	input wire logic [63:0] block_out,
	input wire logic [1:0]  status
);
	import rc2_pkg::*;

	// a held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(block_out) && $stable(status))
		else $error("response changed while stalled");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == STS_OK || status == STS_KEY_LEN || status == STS_ROUNDS))
		else $error("undefined status code");

	// failed key loads carry an all-zero block
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STS_OK |-> block_out == 64'd0)
		else $error("error result with nonzero block");

	// a buffered key byte leaves the request side open
	a_key_byte_open: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type == REQ_KEY && !key_last |=> !req_stall)
		else $error("stall after buffered key byte");

	// a block item occupies the round engine for the next cycle
	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req_type == REQ_ENC || req_type == REQ_DEC)
		|=> req_stall)
		else $error("request side open during block processing");

endmodule

bind rc2_block_cipher rc2_checker u_rc2_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_type  (req_type),
	.key_last  (key_last),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.block_out (block_out),
	.status    (status)
);

`default_nettype wire
